// ===== hw/rtl/asst_pkg.sv =====
// ----------------------------------------------------------------------------
// asst_pkg: shared types and constants of the S5 sleep-type scanner
// Tracker cell layout, AML opcodes and the control word base.
// ----------------------------------------------------------------------------
package asst_pkg;

  // wide enough for every step, length and span count in the parameter range
  localparam int unsigned CtrW = 7;

  localparam logic [7:0] PkgOp      = 8'h12;
  localparam logic [7:0] BytePrefix = 8'h0A;
  localparam logic [15:0] CtlBase   = 16'h2000;

  typedef enum logic [2:0] {
    PH_NAME,
    PH_SEEK,
    PH_LEN,
    PH_VAL,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic              valid;
    phase_e            phase;
    logic [CtrW-1:0]   ctr;
    logic              pend;
    logic [1:0]        cnt;
    logic [7:0]        v0;
    logic [7:0]        v1;
  } trk_t;

  // characters of the name _S5_
  function automatic logic [7:0] name_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h5F;
      2'd1:    c = 8'h53;
      2'd2:    c = 8'h35;
      default: c = 8'h5F;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/asst_cell.sv =====
// ----------------------------------------------------------------------------
// asst_cell: one candidate tracker of the scan chain
// Takes the tracker of its left neighbor and advances it by one table byte.
// ----------------------------------------------------------------------------
module asst_cell #(
  parameter int unsigned SEARCH_LIMIT     = 40,
  parameter int unsigned LENGTH_BYTES_MAX = 5,
  parameter int unsigned VALUE_SPAN       = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          consume_i,
  input  logic [7:0]    byte_i,
  input  asst_pkg::trk_t prev_i,
  output asst_pkg::trk_t cell_o
);

  localparam logic [asst_pkg::CtrW-1:0] SeekMax = asst_pkg::CtrW'(SEARCH_LIMIT);
  localparam logic [asst_pkg::CtrW-1:0] LenLast = asst_pkg::CtrW'(LENGTH_BYTES_MAX - 1);
  localparam logic [asst_pkg::CtrW-1:0] SpanMax = asst_pkg::CtrW'(VALUE_SPAN);

  asst_pkg::trk_t cell_q, cell_d;

  always_comb begin
    cell_d = prev_i;
    if (consume_i && prev_i.valid) begin
      case (prev_i.phase)
        asst_pkg::PH_NAME: begin
          if (byte_i != asst_pkg::name_char(prev_i.ctr[1:0])) begin
            cell_d.valid = 1'b0;
          end else if (prev_i.ctr[1:0] == 2'd3) begin
            cell_d.phase = asst_pkg::PH_SEEK;
            cell_d.ctr   = '0;
          end else begin
            cell_d.ctr = prev_i.ctr + 1'b1;
          end
        end
        asst_pkg::PH_SEEK: begin
          if (byte_i == asst_pkg::PkgOp) begin
            cell_d.phase = asst_pkg::PH_LEN;
            cell_d.ctr   = '0;
          end else if (prev_i.ctr == SeekMax) begin
            cell_d.valid = 1'b0;
          end else begin
            cell_d.ctr = prev_i.ctr + 1'b1;
          end
        end
        asst_pkg::PH_LEN: begin
          if (!byte_i[7] || prev_i.ctr == LenLast) begin
            cell_d.phase = asst_pkg::PH_VAL;
            cell_d.ctr   = '0;
            cell_d.pend  = 1'b0;
          end else begin
            cell_d.ctr = prev_i.ctr + 1'b1;
          end
        end
        asst_pkg::PH_VAL: begin
          cell_d.ctr = prev_i.ctr + 1'b1;
          if (prev_i.pend || (byte_i != asst_pkg::BytePrefix && !byte_i[7])) begin
            if (prev_i.cnt == 2'd0) cell_d.v0 = byte_i;
            else                    cell_d.v1 = byte_i;
            cell_d.cnt  = prev_i.cnt + 1'b1;
            cell_d.pend = 1'b0;
            if (prev_i.cnt == 2'd1 || cell_d.ctr >= SpanMax) cell_d.phase = asst_pkg::PH_DONE;
          end else if (byte_i == asst_pkg::BytePrefix) begin
            // value follows, even past the span end
            cell_d.pend = 1'b1;
          end else if (cell_d.ctr >= SpanMax) begin
            cell_d.phase = asst_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (shift_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== hw/rtl/aml_s5_sleep_type_scanner_top.sv =====
// ----------------------------------------------------------------------------
// aml_s5_sleep_type_scanner_top: S5 sleep-type scanner for AML tables
// Chain of candidate trackers over the table byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one table byte per word in tdata, tlast on the final byte.
//   m_axis: one result word per table, sent after the last byte.
// Every position past the header starts a tracker in the first cell; the
// chain holds SEARCH_LIMIT + LENGTH_BYTES_MAX + VALUE_SPAN + 6 cells (71 at
// the defaults) and each accepted byte advances all trackers one cell. The
// tracker leaving the far end is judged; the first success is kept.
// Throughput: one byte per cycle inside a table. After tlast the chain is
// drained with tready low until every tracker has left the far end, then
// the result is loaded into the output register.
// If the receiver stalls, the result waits in the output register and the
// next table's bytes are taken; a second result waits at the end of drain.
// Reset empties the chain, clears the position and the match.
// Bytes from position 2^32-1 on are dropped; tlast still ends the table.
// ----------------------------------------------------------------------------
module aml_s5_sleep_type_scanner_top #(
  parameter int unsigned HEADER_BYTES     = 36,
  parameter int unsigned SEARCH_LIMIT     = 40,
  parameter int unsigned LENGTH_BYTES_MAX = 5,
  parameter int unsigned VALUE_SPAN       = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] table_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o    // [0] found, [8:1] sleep_type_a,
                                        // [16:9] sleep_type_b, [32:17] control_word_a,
                                        // [48:33] control_word_b, [55:49] zero
);

  localparam int unsigned Reach = SEARCH_LIMIT + LENGTH_BYTES_MAX + VALUE_SPAN + 6;
  localparam int unsigned FcW   = $clog2(Reach);
  localparam logic [FcW-1:0] FcLast = FcW'(Reach - 1);

  asst_pkg::trk_t chain [Reach];
  asst_pkg::trk_t fresh;

  logic [31:0]    pos_q;
  logic           match_q;
  logic [7:0]     ha_q, hb_q;
  logic           flush_q;
  logic [FcW-1:0] fcnt_q;
  logic           ov_q;
  logic [55:0]    od_q;

  logic s_fire, consume, shift, flush_adv, finish, hit;
  logic [7:0] fin_a, fin_b, hit_b;
  logic fin_found;

  assign s_axis_tready_o = !flush_q;
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign consume   = s_fire && (pos_q != 32'hFFFF_FFFF);
  assign finish    = flush_q && (fcnt_q == FcLast) && (!ov_q || m_axis_tready_i);
  assign flush_adv = flush_q && ((fcnt_q != FcLast) || finish);
  assign shift     = consume || flush_adv;

  always_comb begin
    fresh       = '0;
    fresh.valid = consume && (pos_q >= 32'(HEADER_BYTES));
    fresh.phase = asst_pkg::PH_NAME;
  end

  for (genvar k = 0; k < Reach; k++) begin : g_cell
    asst_cell #(
      .SEARCH_LIMIT    (SEARCH_LIMIT),
      .LENGTH_BYTES_MAX(LENGTH_BYTES_MAX),
      .VALUE_SPAN      (VALUE_SPAN)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .consume_i(consume),
      .byte_i   (s_axis_tdata_i),
      .prev_i   ((k == 0) ? fresh : chain[(k == 0) ? 0 : k-1]),
      .cell_o   (chain[k])
    );
  end

  // judge the tracker at the far end of the chain
  assign hit   = chain[Reach-1].valid && (chain[Reach-1].cnt != 2'd0) && !match_q;
  assign hit_b = (chain[Reach-1].cnt == 2'd2) ? chain[Reach-1].v1 : chain[Reach-1].v0;

  assign fin_found = match_q || hit;
  assign fin_a = match_q ? ha_q : (hit ? chain[Reach-1].v0 : 8'd1);
  assign fin_b = match_q ? hb_q : (hit ? hit_b : 8'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      match_q <= 1'b0;
      ha_q    <= '0;
      hb_q    <= '0;
      flush_q <= 1'b0;
      fcnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (m_axis_tready_i) ov_q <= 1'b0;
      if (finish) begin
        pos_q   <= '0;
        match_q <= 1'b0;
        ha_q    <= '0;
        hb_q    <= '0;
        flush_q <= 1'b0;
        fcnt_q  <= '0;
        ov_q    <= 1'b1;
      end else begin
        if (hit) begin
          match_q <= 1'b1;
          ha_q    <= chain[Reach-1].v0;
          hb_q    <= hit_b;
        end
        if (consume) pos_q <= pos_q + 32'd1;
        if (s_fire && s_axis_tlast_i) flush_q <= 1'b1;
        if (flush_adv) fcnt_q <= fcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      od_q <= {7'd0,
               asst_pkg::CtlBase | {fin_b[5:0], 10'd0},
               asst_pkg::CtlBase | {fin_a[5:0], 10'd0},
               fin_b, fin_a, fin_found};
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;

  a_fallback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |->
      (m_axis_tdata_o[8:1] == 8'd1 && m_axis_tdata_o[16:9] == 8'd1))
    else $error("fallback types not 1");

  a_ctl_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[32:17] == (asst_pkg::CtlBase | {m_axis_tdata_o[6:1], 10'd0})))
    else $error("control word a mismatch");

  a_result_after_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(flush_q))
    else $error("result without drain");

  a_match_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (match_q && !finish) |=> (match_q && $stable(ha_q)))
    else $error("held match changed");

endmodule
